FILE: rtl/spt_pkg.sv
// Package for the sampling profile table: payload structs, codes, constants
// and the saturating counter helper. No dependencies.
// Used by every module of the block and by its checker.
package spt_pkg;

    // Fixed field widths
    localparam int ID_W       = 31;
    localparam int NAME_MAX_W = 64;
    localparam int CTR_W      = 32;
    localparam int SLOT_W     = 5;
    localparam int OUTCOME_W  = 3;
    localparam int CFG_W      = 6;

    // Defaults for the top-level parameters
    localparam int DEPTH_DEFAULT      = 32;
    localparam int NAME_BYTES_DEFAULT = 8;

    // Entries between the front and the back
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

    // Result outcome codes
    localparam logic [OUTCOME_W-1:0] OUTCOME_NEW    = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_BUMP   = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_DROP   = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUTCOME_SYSTEM = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUTCOME_SLEEP  = 3'd4;

    // Input item: one profiler tick
    typedef struct packed {
        logic                  ctx_live;
        logic [ID_W-1:0]       ctx_id;
        logic                  ctx_named;
        logic [NAME_MAX_W-1:0] ctx_name;
        logic                  gc_active;
        logic                  sleeping;
    } spt_in_t;

    // Result item
    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic [SLOT_W-1:0]    slot;
        logic [CTR_W-1:0]     slot_count;
        logic [CTR_W-1:0]     slot_gc_count;
        logic [CTR_W-1:0]     total_ticks;
        logic [CTR_W-1:0]     system_ticks;
        logic [CTR_W-1:0]     sleep_ticks;
    } spt_out_t;

    // Class of a tick as decided by the front
    typedef enum logic [1:0] {
        KIND_SCAN,
        KIND_SYSTEM,
        KIND_SLEEP
    } spt_kind_t;

    // Classified tick queued for the back
    typedef struct packed {
        spt_kind_t             kind;
        logic [ID_W-1:0]       id;
        logic                  named;
        logic [NAME_MAX_W-1:0] name;
        logic                  gc;
    } spt_item_t;

    // Back-end scan states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_CMP
    } spt_back_state_t;

    // Increment that stops at all ones
    function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] v);
        logic [CTR_W-1:0] r;
        r = (v == {CTR_W{1'b1}}) ? v : v + 1'b1;
        return r;
    endfunction

endpackage

FILE: rtl/sampling_profile_table_top.sv
// Top level of the sampling profile table: front stage, queue and back end.
// Depends on spt_pkg, spt_front, spt_queue and spt_back.
//
// Each input transfer is one profiler tick and yields exactly one result
// transfer. A tick with no running context is answered from the idle state
// without a scan. A tick with a running context moves the back from idle to
// a scan and then walks the table from slot 0 over the single-port slot
// memory with its registered read: a scan state reads a slot and a compare
// state checks it, so a bump ends in the compare state of the matching slot
// and a new entry or a drop ends in the scan state past the last used or last
// searched slot. Ticks reach the back through the input stage and queue. The
// front keeps taking ticks into the queue while the back scans, and the back
// keeps scanning while an earlier result waits, holding its last step until
// the result register frees. Reset empties the table at once through a fill
// count; no clearing pass is needed. Write entries_in_use through cfg_wr_en
// and cfg_wr_data only while no tick is in flight; it takes effect at once.
module sampling_profile_table_top
    import spt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT,
    parameter int NAME_BYTES  = NAME_BYTES_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  spt_in_t          in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output spt_out_t         out_data
);

    logic      push_valid;
    logic      push_ready;
    spt_item_t push_item;
    logic      q_valid;
    logic      q_pop;
    spt_item_t q_item;

    // Accept and classify ticks
    spt_front #(
        .NAME_BYTES (NAME_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // Decouple front and back
    spt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_item   (q_item)
    );

    // Scan the table and count ticks
    spt_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .NAME_BYTES  (NAME_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

FILE: rtl/spt_front.sv
// Front of the sampling profile table: input stage that takes ticks,
// classifies them and trims the name. Depends on spt_pkg.
module spt_front
    import spt_pkg::*;
#(
    parameter int NAME_BYTES = NAME_BYTES_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  spt_in_t   in_data,
    output logic      push_valid,
    input  logic      push_ready,
    output spt_item_t push_item
);

    localparam logic [NAME_MAX_W-1:0] NAME_MASK =
        {NAME_MAX_W{1'b1}} >> (NAME_MAX_W - NAME_BYTES * 8);

    logic      stage_valid_reg;
    logic      stage_valid_next;
    spt_item_t stage_reg;
    spt_item_t stage_next;
    logic      in_xfer;

    assign in_ready   = !stage_valid_reg || push_ready;
    assign in_xfer    = in_valid && in_ready;
    assign push_valid = stage_valid_reg;
    assign push_item  = stage_reg;

    // Classify the tick and keep only the stored name bytes
    always_comb
    begin
        stage_next.id    = in_data.ctx_id;
        stage_next.named = in_data.ctx_named;
        stage_next.name  = in_data.ctx_named ? (in_data.ctx_name & NAME_MASK) : '0;
        stage_next.gc    = in_data.gc_active;
        if (in_data.ctx_live)
        begin
            stage_next.kind = KIND_SCAN;
        end
        else if (in_data.sleeping)
        begin
            stage_next.kind = KIND_SLEEP;
        end
        else
        begin
            stage_next.kind = KIND_SYSTEM;
        end
    end

    // Hold the stage until the queue takes it
    always_comb
    begin
        if (in_xfer)
        begin
            stage_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

FILE: rtl/spt_queue.sv
// Short queue between the front and the back of the sampling profile table.
// Head is visible without a registered read. Depends on spt_pkg.
module spt_queue
    import spt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  spt_item_t push_item,
    output logic      pop_valid,
    input  logic      pop,
    output spt_item_t pop_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    spt_item_t          slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/spt_back.sv
// Back of the sampling profile table: slot memory, scan sequencer, tick
// counters, size register and result register. Depends on spt_pkg.
module spt_back
    import spt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT,
    parameter int NAME_BYTES  = NAME_BYTES_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             q_valid,
    input  spt_item_t        q_item,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output spt_out_t         out_data
);

    localparam int NAME_W  = NAME_BYTES * 8;
    localparam int KEY_W   = ID_W + 1 + NAME_W;
    localparam int ENT_W   = KEY_W + 2 * CTR_W;
    localparam int DEPTH_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int IDX_W   = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W   = (IDX_W > CFG_W) ? IDX_W : CFG_W;

    // Slot memory: {id, named, name, hits, gc hits}
    logic [ENT_W-1:0]     mem [TABLE_DEPTH];
    logic [ENT_W-1:0]     rd_ent_reg;

    spt_back_state_t      state_reg;
    spt_back_state_t      state_next;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;
    logic [IDX_W-1:0]     fill_reg;
    logic [IDX_W-1:0]     fill_next;
    logic [CFG_W-1:0]     entries_reg;
    logic [CTR_W-1:0]     total_reg;
    logic [CTR_W-1:0]     system_reg;
    logic [CTR_W-1:0]     sleep_reg;
    logic [CTR_W-1:0]     total_next;
    logic [CTR_W-1:0]     system_next;
    logic [CTR_W-1:0]     sleep_next;
    logic                 out_valid_reg;
    spt_out_t             out_reg;
    spt_out_t             res_next;

    logic [IDX_W-1:0]     limit;
    logic [KEY_W-1:0]     item_key;
    logic [CTR_W-1:0]     rd_hits;
    logic [CTR_W-1:0]     rd_gc;
    logic [CTR_W-1:0]     wr_hits;
    logic [CTR_W-1:0]     wr_gc;
    logic                 match;
    logic                 end_drop;
    logic                 scan_end;
    logic                 out_free;
    logic                 load;
    logic                 mem_rd;
    logic                 mem_wr;
    logic                 new_entry;
    logic [OUTCOME_W-1:0] outcome_sel;

    // Slots searched: the register value, capped at the table depth
    assign limit = (CMP_W'(entries_reg) > CMP_W'(TABLE_DEPTH)) ? IDX_W'(TABLE_DEPTH)
                                                                : IDX_W'(entries_reg);

    // Unnamed ticks carry a zero name, so a whole-key compare covers the name rule
    assign item_key = {q_item.id, q_item.named, q_item.name[NAME_W-1:0]};
    assign rd_hits  = rd_ent_reg[2*CTR_W-1:CTR_W];
    assign rd_gc    = rd_ent_reg[CTR_W-1:0];
    assign match    = (rd_ent_reg[ENT_W-1:2*CTR_W] == item_key);

    // Used slots always form a prefix, so the fill count marks the first empty one
    assign end_drop = (idx_reg >= limit);
    assign scan_end = end_drop || (idx_reg >= fill_reg);
    assign out_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && (q_item.kind == KIND_SCAN))
                begin
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                if (scan_end)
                begin
                    if (out_free)
                    begin
                        state_next = BK_IDLE;
                    end
                end
                else
                begin
                    state_next = BK_CMP;
                end
            end
            BK_CMP:
            begin
                if (match)
                begin
                    if (out_free)
                    begin
                        state_next = BK_IDLE;
                    end
                end
                else
                begin
                    state_next = BK_SCAN;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        load        = 1'b0;
        mem_rd      = 1'b0;
        mem_wr      = 1'b0;
        new_entry   = 1'b0;
        idx_next    = idx_reg;
        outcome_sel = OUTCOME_SYSTEM;
        case (state_reg)
            BK_IDLE:
            begin
                idx_next    = '0;
                outcome_sel = (q_item.kind == KIND_SLEEP) ? OUTCOME_SLEEP : OUTCOME_SYSTEM;
                load        = q_valid && (q_item.kind != KIND_SCAN) && out_free;
            end
            BK_SCAN:
            begin
                outcome_sel = end_drop ? OUTCOME_DROP : OUTCOME_NEW;
                if (scan_end)
                begin
                    load      = out_free;
                    new_entry = out_free && !end_drop;
                    mem_wr    = new_entry;
                end
                else
                begin
                    mem_rd = 1'b1;
                end
            end
            BK_CMP:
            begin
                outcome_sel = OUTCOME_BUMP;
                if (match)
                begin
                    load   = out_free;
                    mem_wr = out_free;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    assign q_pop     = load;
    assign fill_next = new_entry ? fill_reg + 1'b1 : fill_reg;

    // Slot counts after the update
    always_comb
    begin
        if (state_reg == BK_CMP)
        begin
            wr_hits = sat_inc(rd_hits);
            wr_gc   = q_item.gc ? sat_inc(rd_gc) : rd_gc;
        end
        else
        begin
            wr_hits = CTR_W'(1);
            wr_gc   = CTR_W'(q_item.gc);
        end
    end

    // Tick counters after this tick
    always_comb
    begin
        total_next  = sat_inc(total_reg);
        system_next = (q_item.kind == KIND_SYSTEM) ? sat_inc(system_reg) : system_reg;
        sleep_next  = (q_item.kind == KIND_SLEEP) ? sat_inc(sleep_reg) : sleep_reg;
    end

    // Build the result
    always_comb
    begin
        res_next.outcome      = outcome_sel;
        res_next.total_ticks  = total_next;
        res_next.system_ticks = system_next;
        res_next.sleep_ticks  = sleep_next;
        if ((outcome_sel == OUTCOME_NEW) || (outcome_sel == OUTCOME_BUMP))
        begin
            res_next.slot          = SLOT_W'(idx_reg);
            res_next.slot_count    = wr_hits;
            res_next.slot_gc_count = wr_gc;
        end
        else
        begin
            res_next.slot          = '0;
            res_next.slot_count    = '0;
            res_next.slot_gc_count = '0;
        end
    end

    // Control state, counters and size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            idx_reg       <= '0;
            fill_reg      <= '0;
            entries_reg   <= CFG_RESET;
            total_reg     <= '0;
            system_reg    <= '0;
            sleep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            fill_reg  <= fill_next;
            if (cfg_wr_en)
            begin
                entries_reg <= cfg_wr_data;
            end
            if (load)
            begin
                total_reg     <= total_next;
                system_reg    <= system_next;
                sleep_reg     <= sleep_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= res_next;
        end
    end

    // Slot memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[idx_reg[DEPTH_W-1:0]] <= {item_key, wr_hits, wr_gc};
        end
        if (mem_rd)
        begin
            rd_ent_reg <= mem[idx_reg[DEPTH_W-1:0]];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: rtl/spt_checker.sv
// Port-level checker for the sampling profile table and its bind.
// Depends on spt_pkg and sampling_profile_table_top.
module spt_checker
    import spt_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input spt_out_t         out_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Drop, system and sleep results report no slot
    a_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.outcome == OUTCOME_DROP ||
                      out_data.outcome == OUTCOME_SYSTEM ||
                      out_data.outcome == OUTCOME_SLEEP)
        |-> out_data.slot == '0 && out_data.slot_count == '0 &&
            out_data.slot_gc_count == '0)
        else $error("slot fields set without a slot transfer");

    // A new entry starts at one sample
    a_new_entry: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.outcome == OUTCOME_NEW
        |-> out_data.slot_count == CTR_W'(1) && out_data.slot_gc_count <= CTR_W'(1))
        else $error("new entry counts wrong");

    // A bumped slot has more than one sample, and its gc samples never exceed its samples
    a_gc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.outcome == OUTCOME_BUMP
        |-> out_data.slot_count > CTR_W'(1) &&
            out_data.slot_gc_count <= out_data.slot_count)
        else $error("bumped slot counts inconsistent");

    // Total ticks cover system and sleep ticks
    a_totals: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.total_ticks != '0 &&
            out_data.total_ticks >= out_data.system_ticks &&
            out_data.total_ticks >= out_data.sleep_ticks)
        else $error("tick counters inconsistent");

endmodule

bind sampling_profile_table_top spt_checker u_spt_checker (.*);
